@@ hw/rtl/beo_pkg.sv @@
// ----------------------------------------------------------------------------
// Broadcast element offset package
// Shared widths, register indexes, the pipeline lane type and a helper.
// ----------------------------------------------------------------------------
package beo_pkg;

  localparam int ID_W     = 32;
  localparam int DIM_W    = 16;
  localparam int MASK_W   = 4;
  localparam int REG_DIMS = 4;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = ID_W;

  localparam logic [CFG_IDX_W-1:0] REG_DIM0_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM1_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM2_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM3_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_MASK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MASK    = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  q;
    logic [DIM_W-1:0] r;
    logic [ID_W-1:0]  xo;
    logic [ID_W-1:0]  yo;
    logic [ID_W-1:0]  xs;
    logic [ID_W-1:0]  ys;
    logic [ID_W-1:0]  px;
    logic [ID_W-1:0]  py;
  } lane_t;

  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] s);
    eff_size = (s == '0) ? DIM_W'(1) : s;
  endfunction

endpackage

@@ hw/rtl/beo_div_cell.sv @@
// ----------------------------------------------------------------------------
// Division cell
// One restoring division step of the running quotient by a dimension size.
// ----------------------------------------------------------------------------
module beo_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  beo_pkg::lane_t            in_lane,
  input  logic [beo_pkg::DIM_W-1:0] divisor,
  output logic                      out_vld,
  output beo_pkg::lane_t            out_lane
);
  import beo_pkg::*;

  logic [DIM_W:0] rs;
  lane_t          lane_next;

  always_comb begin
    lane_next = in_lane;
    rs = {in_lane.r, in_lane.q[ID_W-1]};
    if (rs >= {1'b0, divisor}) begin
      lane_next.r = DIM_W'(rs - {1'b0, divisor});
      lane_next.q = {in_lane.q[ID_W-2:0], 1'b1};
    end else begin
      lane_next.r = rs[DIM_W-1:0];
      lane_next.q = {in_lane.q[ID_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_lane <= lane_next;
  end

endmodule

@@ hw/rtl/beo_mac_cell.sv @@
// ----------------------------------------------------------------------------
// Digit weighting cell
// Weights one digit by the X and Y strides, accumulates, and grows strides.
// ----------------------------------------------------------------------------
module beo_mac_cell #(
  parameter int USE_QUOT = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  beo_pkg::lane_t            in_lane,
  input  logic [beo_pkg::DIM_W-1:0] size,
  input  logic                      x_bcast,
  input  logic                      y_bcast,
  output logic                      out_vld,
  output beo_pkg::lane_t            out_lane
);
  import beo_pkg::*;

  logic [ID_W-1:0]   digit;
  logic [2*ID_W-1:0] prod_x;
  logic [2*ID_W-1:0] prod_y;
  logic              mid_vld;
  lane_t             mid_lane;
  lane_t             mid_next;
  lane_t             out_next;
  logic [ID_W+DIM_W-1:0] sx;
  logic [ID_W+DIM_W-1:0] sy;

  always_comb begin
    digit  = (USE_QUOT != 0) ? in_lane.q : {{(ID_W-DIM_W){1'b0}}, in_lane.r};
    prod_x = digit * in_lane.xs;
    prod_y = digit * in_lane.ys;
    sx     = mid_lane.xs * size;
    sy     = mid_lane.ys * size;

    mid_next    = in_lane;
    mid_next.px = x_bcast ? '0 : prod_x[ID_W-1:0];
    mid_next.py = y_bcast ? '0 : prod_y[ID_W-1:0];

    out_next    = mid_lane;
    out_next.r  = '0;
    out_next.xo = mid_lane.xo + mid_lane.px;
    out_next.yo = mid_lane.yo + mid_lane.py;
    out_next.xs = x_bcast ? mid_lane.xs : sx[ID_W-1:0];
    out_next.ys = y_bcast ? mid_lane.ys : sy[ID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      mid_vld <= in_vld;
      out_vld <= mid_vld;
    end
  end

  always_ff @(posedge clk) begin
    mid_lane <= mid_next;
    out_lane <= out_next;
  end

endmodule

@@ hw/rtl/broadcast_element_offset_unit.sv @@
// done rises once a request has passed the head, cell and output registers.
// Throughput: one request per cycle; busy is always low and results cannot be stalled.
// The depth is set by the chain of one-bit division cells, 32 per inner dimension.
// Reset clears the pipeline valid bits and sets sizes to 1 and masks to 0.
// ----------------------------------------------------------------------------
// Broadcast element offset unit
// Splits a linear output element id over the dimensions and gives X, Y, Z offsets.
// ----------------------------------------------------------------------------
module broadcast_element_offset_unit #(
  parameter int RANK = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [beo_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [beo_pkg::DIM_W-1:0]     wr_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [beo_pkg::ID_W-1:0]      elem_id,
  output logic                          done,
  output logic [beo_pkg::ID_W-1:0]      x_offset,
  output logic [beo_pkg::ID_W-1:0]      y_offset,
  output logic [beo_pkg::ID_W-1:0]      z_offset,
  output logic                          in_range
);
  import beo_pkg::*;

  localparam int LINK_PER_DIM = DIV_STEPS + 1;
  localparam int FINAL_LINK   = (RANK - 1) * LINK_PER_DIM;
  localparam int NLINK        = FINAL_LINK + 2;

  logic [DIM_W-1:0]  dim_len [REG_DIMS];
  logic [MASK_W-1:0] x_mask;
  logic [MASK_W-1:0] y_mask;
  logic              empty;

  logic  head_vld;
  lane_t head_lane;
  lane_t head_next;

  lane_t lanes [NLINK];
  logic  vld   [NLINK];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_DIMS; i++) begin
        dim_len[i] <= DIM_W'(1);
      end
      x_mask <= '0;
      y_mask <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_DIM0_SIZE: dim_len[0] <= wr_data;
        REG_DIM1_SIZE: dim_len[1] <= wr_data;
        REG_DIM2_SIZE: dim_len[2] <= wr_data;
        REG_DIM3_SIZE: dim_len[3] <= wr_data;
        REG_X_MASK:    x_mask <= wr_data[MASK_W-1:0];
        REG_Y_MASK:    y_mask <= wr_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    empty = 1'b0;
    for (int i = 0; i < REG_DIMS; i++) begin
      if (i < RANK && dim_len[i] == '0) begin
        empty = 1'b1;
      end
    end
  end

  always_comb begin
    head_next    = '0;
    head_next.id = elem_id;
    head_next.q  = elem_id;
    head_next.xs = ID_W'(1);
    head_next.ys = ID_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= 1'b0;
    end else begin
      head_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    head_lane <= head_next;
  end

  assign vld[0]   = head_vld;
  assign lanes[0] = head_lane;

  for (genvar j = 0; j < RANK - 1; j++) begin : g_dim
    localparam int K    = RANK - 1 - j;
    localparam int BASE = j * LINK_PER_DIM;
    logic [DIM_W-1:0] sz;
    logic             bx;
    logic             by;

    if (K < REG_DIMS) begin : g_reg
      assign sz = eff_size(dim_len[K]);
      assign bx = x_mask[K];
      assign by = y_mask[K];
    end else begin : g_unit
      assign sz = DIM_W'(1);
      assign bx = 1'b0;
      assign by = 1'b0;
    end

    for (genvar c = 0; c < DIV_STEPS; c++) begin : g_step
      beo_div_cell u_div (
        .clk      (clk),
        .rst      (rst),
        .in_vld   (vld[BASE+c]),
        .in_lane  (lanes[BASE+c]),
        .divisor  (sz),
        .out_vld  (vld[BASE+c+1]),
        .out_lane (lanes[BASE+c+1])
      );
    end

    beo_mac_cell #(.USE_QUOT(0)) u_mac (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (vld[BASE+DIV_STEPS]),
      .in_lane  (lanes[BASE+DIV_STEPS]),
      .size     (sz),
      .x_bcast  (bx),
      .y_bcast  (by),
      .out_vld  (vld[BASE+DIV_STEPS+1]),
      .out_lane (lanes[BASE+DIV_STEPS+1])
    );
  end

  beo_mac_cell #(.USE_QUOT(1)) u_mac_last (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (vld[FINAL_LINK]),
    .in_lane  (lanes[FINAL_LINK]),
    .size     (eff_size(dim_len[0])),
    .x_bcast  (x_mask[0]),
    .y_bcast  (y_mask[0]),
    .out_vld  (vld[FINAL_LINK+1]),
    .out_lane (lanes[FINAL_LINK+1])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[FINAL_LINK+1];
    end
  end

  always_ff @(posedge clk) begin
    x_offset <= lanes[FINAL_LINK+1].xo;
    y_offset <= lanes[FINAL_LINK+1].yo;
    z_offset <= lanes[FINAL_LINK+1].id;
    in_range <= !empty &&
                (lanes[FINAL_LINK+1].q < {{(ID_W-DIM_W){1'b0}}, eff_size(dim_len[0])});
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Broadcast element offset unit testbench
// Drives random and corner element ids under several shapes and broadcast
// masks, predicts the X, Y and Z offsets and the range flag for each request,
// and compares every result in order against the predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import beo_pkg::*;

  localparam int RANK = 4;
  localparam int LATENCY = 34 * (RANK - 1) + 4;

  typedef struct packed {
    logic [ID_W-1:0] xo;
    logic [ID_W-1:0] yo;
    logic [ID_W-1:0] zo;
    logic            inr;
  } offsets_t;

  class offset_scoreboard;
    logic [DIM_W-1:0]  sizes[REG_DIMS];
    logic [MASK_W-1:0] xmask, ymask;
    offsets_t          pending[$];
    int                errors;
    int                checked;

    function new();
      for (int i = 0; i < REG_DIMS; i++) sizes[i] = 1;
      xmask = 0;
      ymask = 0;
      errors = 0;
      checked = 0;
    endfunction

    function offsets_t compute_offsets(logic [ID_W-1:0] id);
      logic [63:0] sz[RANK], zs[RANK], xs[RANK], ys[RANK];
      logic [63:0] zacc, xacc, yacc, rem, d, xo, yo, zo;
      bit empty, past;
      offsets_t r;
      zacc = 1; xacc = 1; yacc = 1; xo = 0; yo = 0; zo = 0;
      empty = 0; past = 0; rem = id;
      for (int i = 0; i < RANK; i++) begin
        sz[i] = (i < REG_DIMS) ? sizes[i] : 1;
        if (sz[i] == 0) begin
          empty = 1;
          sz[i] = 1;
        end
      end
      for (int i = RANK - 1; i >= 0; i--) begin
        zs[i] = zacc;
        xs[i] = (i < REG_DIMS && xmask[i]) ? 0 : xacc;
        ys[i] = (i < REG_DIMS && ymask[i]) ? 0 : yacc;
        if (zacc > 64'hFFFF_FFFF) past = 1;
        if (!past) zacc *= sz[i];
        if (!(i < REG_DIMS && xmask[i])) xacc *= sz[i];
        if (!(i < REG_DIMS && ymask[i])) yacc *= sz[i];
      end
      for (int i = 0; i < RANK; i++) begin
        d = rem / zs[i];
        rem -= d * zs[i];
        xo += d * xs[i];
        yo += d * ys[i];
        zo += d * zs[i];
      end
      r.xo = xo[31:0];
      r.yo = yo[31:0];
      r.zo = zo[31:0];
      r.inr = !empty && (past || id < zacc);
      return r;
    endfunction

    function void note_request(logic [ID_W-1:0] id);
      pending.push_back(compute_offsets(id));
    endfunction

    task check_result(offsets_t got);
      offsets_t exp;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding", got, got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) report_mismatch("offset mismatch", got, exp);
    endtask

    task report_mismatch(string what, offsets_t got, offsets_t exp);
      errors++;
      $display("MISMATCH %s: got x=%h y=%h z=%h r=%b exp x=%h y=%h z=%h r=%b", what,
               got.xo, got.yo, got.zo, got.inr, exp.xo, exp.yo, exp.zo, exp.inr);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic wr_en = 0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [DIM_W-1:0] wr_data = '0;
  logic start = 0;
  logic [ID_W-1:0] elem_id = '0;
  logic busy, done, in_range;
  logic [ID_W-1:0] x_offset, y_offset, z_offset;

  offset_scoreboard sb = new();
  int sent = 0;

  broadcast_element_offset_unit #(.RANK(RANK)) dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result('{x_offset, y_offset, z_offset, in_range});
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(negedge clk);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 0;
    if (idx < REG_DIMS) sb.sizes[idx] = val;
    else if (idx == REG_X_MASK) sb.xmask = val[MASK_W-1:0];
    else if (idx == REG_Y_MASK) sb.ymask = val[MASK_W-1:0];
  endtask

  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task set_shape(logic [DIM_W-1:0] s0, s1, s2, s3, logic [3:0] xm, ym);
    drain();
    write_reg(REG_DIM0_SIZE, s0);
    write_reg(REG_DIM1_SIZE, s1);
    write_reg(REG_DIM2_SIZE, s2);
    write_reg(REG_DIM3_SIZE, s3);
    write_reg(REG_X_MASK, {12'h0, xm});
    write_reg(REG_Y_MASK, {12'h0, ym});
  endtask

  task send_request(logic [ID_W-1:0] id, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1;
    elem_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(id);
    sent++;
  endtask

  task end_burst();
    @(negedge clk);
    start <= 0;
  endtask

  function logic [DIM_W-1:0] rand_size();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 0;
      2: return 1;
      3: return DIM_W'($urandom);
      default: return DIM_W'($urandom_range(1, 12));
    endcase
  endfunction

  function logic [ID_W-1:0] rand_id();
    logic [63:0] total;
    total = 1;
    for (int i = 0; i < REG_DIMS; i++) total *= (sb.sizes[i] == 0) ? 1 : sb.sizes[i];
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return (total > 64'hFFFF_FFFF) ? $urandom
                                              : ID_W'($urandom % (total + 2));
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_request(0, 0);
    send_request(32'hFFFF_FFFF, 0);
    end_burst();
    set_shape(2, 3, 4, 5, 4'b0101, 4'b1010);
    for (int i = 0; i < 8; i++) send_request(i * 17, 0);
    send_request(119, 0);
    send_request(120, 0);
    end_burst();
    set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b0000, 4'b1111);
    send_request(0, 0);
    send_request(32'hFFFF_FFFF, 0);
    send_request(32'h8000_0001, 0);
    end_burst();
    set_shape(3, 0, 4, 5, 4'b1111, 4'b0000);
    send_request(7, 0);
    send_request(32'hFFFF_FFFF, 0);
    end_burst();
    for (int phase = 0; phase < 15; phase++) begin
      set_shape(rand_size(), rand_size(), rand_size(), rand_size(),
                4'($urandom), 4'($urandom));
      for (int k = 0; k < 50; k++) begin
        send_request(rand_id(), phase % 3 != 0);
        if (phase == 7 && k == 25) begin
          end_burst();
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      end_burst();
    end
    drain();
    $display("Checked %0d results from %0d requests over 19 shape and mask settings.",
             sb.checked, sent);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
